// ===== hdl/vocab_hash_counter_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the vocabulary hash counter checker.
// Both macros expect clk_i and rst_ni in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef VOCAB_HASH_COUNTER_UNIT_MACROS_SVH
`define VOCAB_HASH_COUNTER_UNIT_MACROS_SVH

// Same-cycle implication
`define VHC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define VHC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/vhc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vhc_pkg
// Sizes, codes and record types shared by the vocabulary hash counter.
// ----------------------------------------------------------------------------
package vhc_pkg;

  localparam int unsigned TABLE_SLOTS = 4096;
  localparam int unsigned MAX_ENTRIES = 2048;
  localparam int unsigned MAX_KEY_LEN = 32;

  localparam int unsigned SlotW   = $clog2(TABLE_SLOTS);
  localparam int unsigned EntryW  = $clog2(MAX_ENTRIES);
  localparam int unsigned UsedW   = EntryW + 1;
  localparam int unsigned KeyLenW = $clog2(MAX_KEY_LEN + 1);
  localparam int unsigned KeyIdxW = $clog2(MAX_KEY_LEN);
  localparam int unsigned KeyBits = MAX_KEY_LEN * 8;
  localparam int unsigned OccW    = 32;
  localparam int unsigned StatusW = 3;

  localparam logic [63:0] HASH_START = 64'd2166136261;
  localparam logic [63:0] HASH_MULT  = 64'd16777619;
  localparam logic [OccW-1:0] OCC_MAX = {OccW{1'b1}};

  typedef enum logic [StatusW-1:0] {
    STAT_EXISTING  = 3'd0,
    STAT_INSERTED  = 3'd1,
    STAT_NOT_FOUND = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_TOO_LONG  = 3'd4
  } status_e;

  // Key state after the current byte
  typedef struct packed {
    logic [SlotW-1:0]   home;
    logic [KeyLenW-1:0] len;
    logic               ovf;
  } key_info_t;

  typedef struct packed {
    logic              valid;
    logic [EntryW-1:0] entry;
  } slot_t;

  typedef struct packed {
    logic [KeyBits-1:0] key;
    logic [KeyLenW-1:0] len;
    logic [OccW-1:0]    occ;
  } entry_t;

endpackage

// ===== hdl/vhc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vhc_in_if / vhc_out_if
// Valid/ready channels for key bytes and lookup results.
// ----------------------------------------------------------------------------
interface vhc_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] key_byte;
  logic       key_last;

  modport source (output valid, req_type, key_byte, key_last, input ready);
  modport sink   (input valid, req_type, key_byte, key_last, output ready);
endinterface

interface vhc_out_if;
  logic                            valid;
  logic                            ready;
  logic [vhc_pkg::StatusW-1:0]     status;
  logic [vhc_pkg::EntryW-1:0]      entry_index;
  logic [vhc_pkg::OccW-1:0]        occurrences;
  logic [vhc_pkg::SlotW-1:0]       slot_index;

  modport source (output valid, status, entry_index, occurrences, slot_index, input ready);
  modport sink   (input valid, status, entry_index, occurrences, slot_index, output ready);
endinterface

// ===== hdl/vhc_key_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vhc_key_front
// Folds key bytes into the hash and collects them in the key buffer.
// Only the low slot bits of the hash are kept: they alone set the home slot.
// ----------------------------------------------------------------------------
module vhc_key_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         beat_i,
  input  logic [7:0]                   byte_i,
  input  logic                         last_i,
  output logic [vhc_pkg::KeyBits-1:0]  buf_o,
  output vhc_pkg::key_info_t           info_o
);

  localparam int unsigned SlotW = vhc_pkg::SlotW;

  logic [SlotW-1:0]            hash_q, hash_d;
  logic [vhc_pkg::KeyLenW-1:0] len_q, len_d;
  logic                        ovf_q, ovf_d;
  logic                        room;
  logic [31:0]                 ext32;
  logic [2*SlotW-1:0]          prod;
  logic [7:0]                  buf_q [vhc_pkg::MAX_KEY_LEN];

  // Hash step on the sign-extended byte, low bits only
  always_comb begin
    ext32  = {{24{byte_i[7]}}, byte_i};
    prod   = (hash_q ^ ext32[SlotW-1:0]) * vhc_pkg::HASH_MULT[SlotW-1:0];
    hash_d = prod[SlotW-1:0];
    room   = len_q < vhc_pkg::KeyLenW'(vhc_pkg::MAX_KEY_LEN);
    len_d  = room ? len_q + 1'b1 : len_q;
    ovf_d  = ovf_q | ~room;
  end

  assign info_o = '{home: hash_d, len: len_d, ovf: ovf_d};

  // Key state; a last byte returns it to the start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= vhc_pkg::HASH_START[SlotW-1:0];
      len_q  <= '0;
      ovf_q  <= 1'b0;
    end else if (beat_i) begin
      if (last_i) begin
        hash_q <= vhc_pkg::HASH_START[SlotW-1:0];
        len_q  <= '0;
        ovf_q  <= 1'b0;
      end else begin
        hash_q <= hash_d;
        len_q  <= len_d;
        ovf_q  <= ovf_d;
      end
    end
  end

  // Key buffer, bytes past the limit are dropped
  always_ff @(posedge clk_i) begin
    if (beat_i && room) begin
      buf_q[len_q[vhc_pkg::KeyIdxW-1:0]] <= byte_i;
    end
  end

  always_comb begin
    for (int i = 0; i < vhc_pkg::MAX_KEY_LEN; i++) begin
      buf_o[i*8 +: 8] = buf_q[i];
    end
  end

endmodule

// ===== hdl/vhc_slot_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vhc_slot_table
// Hash slot memory: valid bit and dense entry number per slot.
// ----------------------------------------------------------------------------
module vhc_slot_table (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [vhc_pkg::SlotW-1:0] waddr_i,
  input  vhc_pkg::slot_t            wdata_i,
  input  logic [vhc_pkg::SlotW-1:0] raddr_i,
  output vhc_pkg::slot_t            rdata_o
);

  vhc_pkg::slot_t mem [vhc_pkg::TABLE_SLOTS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hdl/vhc_entry_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vhc_entry_store
// Dense entry memory: stored key, key length and occurrence count.
// ----------------------------------------------------------------------------
module vhc_entry_store (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [vhc_pkg::EntryW-1:0] waddr_i,
  input  vhc_pkg::entry_t            wdata_i,
  input  logic [vhc_pkg::EntryW-1:0] raddr_i,
  output vhc_pkg::entry_t            rdata_o
);

  vhc_pkg::entry_t mem [vhc_pkg::MAX_ENTRIES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hdl/vocab_hash_counter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vocab_hash_counter_unit
// Word counter: hashes keys byte by byte, probes the slot table linearly,
// compares stored keys and inserts, counts or looks up entries.
// ----------------------------------------------------------------------------
// Channel | Dir | Beat
// in_i    | in  | req_type, key_byte, key_last: one key byte
// out_o   | out | status, entry_index, occurrences, slot_index: one result
//
// A byte that is not last only updates the key state. A last byte starts
// the probe: each probed slot passes S_SLOT (slot read), then, if it is
// occupied, S_ENTRY (entry read and key compare); a probe that ends on an
// empty slot needs only its slot read. The slot and entry memories have
// registered reads, which sets this split. An overlong key is answered
// without a probe, its result registered as its last byte is taken. After
// reset a pass clears the slot table, one slot a cycle, with in_i.ready
// low. A stalled result holds the output register and blocks new bytes.
// ----------------------------------------------------------------------------
module vocab_hash_counter_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  vhc_in_if.sink    in_i,
  vhc_out_if.source out_o
);

  localparam int unsigned SlotW  = vhc_pkg::SlotW;
  localparam int unsigned EntryW = vhc_pkg::EntryW;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_SLOT  = 2'd2;
  localparam logic [1:0] S_ENTRY = 2'd3;

  logic [1:0]                  state_q, state_d;
  logic [SlotW-1:0]            clr_q, clr_d;
  logic [SlotW-1:0]            slot_q, slot_d;
  logic [SlotW-1:0]            home_q, home_d;
  logic [SlotW-1:0]            cnt_q, cnt_d;
  logic [EntryW-1:0]           ent_q, ent_d;
  logic [vhc_pkg::KeyLenW-1:0] len_q, len_d;
  logic                        lookup_q, lookup_d;
  logic [vhc_pkg::UsedW-1:0]   used_q, used_d;

  logic                        ov_q;
  vhc_pkg::status_e            ostat_q;
  logic [EntryW-1:0]           oent_q;
  logic [vhc_pkg::OccW-1:0]    oocc_q;
  logic [SlotW-1:0]            oslot_q;

  logic                        finish;
  vhc_pkg::status_e            fin_stat;
  logic [EntryW-1:0]           fin_ent;
  logic [vhc_pkg::OccW-1:0]    fin_occ;
  logic [SlotW-1:0]            fin_slot;

  logic                        in_ready, in_beat, out_beat;
  logic [vhc_pkg::KeyBits-1:0] key_buf;
  vhc_pkg::key_info_t          kinfo;

  logic                        slot_we;
  logic [SlotW-1:0]            slot_waddr, slot_raddr;
  vhc_pkg::slot_t              slot_wdata, slot_rd;
  logic                        ent_we;
  logic [EntryW-1:0]           ent_waddr, ent_raddr;
  vhc_pkg::entry_t             ent_wdata, ent_rd;
  logic                        key_hit;

  assign in_ready = (state_q == S_IDLE) && (!ov_q || out_o.ready);
  assign in_beat  = in_i.valid && in_ready;
  assign out_beat = ov_q && out_o.ready;

  vhc_key_front u_key (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .beat_i (in_beat),
    .byte_i (in_i.key_byte),
    .last_i (in_i.key_last),
    .buf_o  (key_buf),
    .info_o (kinfo)
  );

  vhc_slot_table u_slots (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rd)
  );

  vhc_entry_store u_entries (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rd)
  );

  // Stored key against buffered key, only the first len bytes count
  always_comb begin
    key_hit = (ent_rd.len == len_q);
    for (int i = 0; i < vhc_pkg::MAX_KEY_LEN; i++) begin
      if ((vhc_pkg::KeyLenW'(i) < len_q) && (ent_rd.key[i*8 +: 8] != key_buf[i*8 +: 8])) begin
        key_hit = 1'b0;
      end
    end
  end

  // Probe sequencer
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    slot_d     = slot_q;
    home_d     = home_q;
    cnt_d      = cnt_q;
    ent_d      = ent_q;
    len_d      = len_q;
    lookup_d   = lookup_q;
    used_d     = used_q;
    finish     = 1'b0;
    fin_stat   = vhc_pkg::STAT_EXISTING;
    fin_ent    = '0;
    fin_occ    = '0;
    fin_slot   = '0;
    slot_we    = 1'b0;
    slot_waddr = slot_q;
    slot_wdata = '0;
    slot_raddr = slot_q + 1'b1;
    ent_we     = 1'b0;
    ent_waddr  = ent_q;
    ent_wdata  = ent_rd;
    ent_raddr  = ent_q;
    case (state_q)
      S_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_q;
        clr_d      = clr_q + 1'b1;
        if (clr_q == SlotW'(vhc_pkg::TABLE_SLOTS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        slot_raddr = kinfo.home;
        if (in_beat && in_i.key_last) begin
          if (kinfo.ovf) begin
            finish   = 1'b1;
            fin_stat = vhc_pkg::STAT_TOO_LONG;
          end else begin
            home_d   = kinfo.home;
            slot_d   = kinfo.home;
            cnt_d    = '0;
            len_d    = kinfo.len;
            lookup_d = in_i.req_type;
            state_d  = S_SLOT;
          end
        end
      end
      S_SLOT: begin
        if (!slot_rd.valid) begin
          // Empty slot ends the probe
          state_d  = S_IDLE;
          finish   = 1'b1;
          fin_slot = slot_q;
          if (lookup_q) begin
            fin_stat = vhc_pkg::STAT_NOT_FOUND;
          end else if (used_q >= vhc_pkg::UsedW'(vhc_pkg::MAX_ENTRIES)) begin
            fin_stat = vhc_pkg::STAT_FULL;
          end else begin
            ent_we     = 1'b1;
            ent_waddr  = used_q[EntryW-1:0];
            ent_wdata  = '{key: key_buf, len: len_q, occ: vhc_pkg::OccW'(1)};
            slot_we    = 1'b1;
            slot_waddr = slot_q;
            slot_wdata = '{valid: 1'b1, entry: used_q[EntryW-1:0]};
            used_d     = used_q + 1'b1;
            fin_stat   = vhc_pkg::STAT_INSERTED;
            fin_ent    = used_q[EntryW-1:0];
            fin_occ    = vhc_pkg::OccW'(1);
          end
        end else begin
          ent_raddr = slot_rd.entry;
          ent_d     = slot_rd.entry;
          state_d   = S_ENTRY;
        end
      end
      S_ENTRY: begin
        if (key_hit) begin
          state_d  = S_IDLE;
          finish   = 1'b1;
          fin_stat = vhc_pkg::STAT_EXISTING;
          fin_ent  = ent_q;
          fin_slot = slot_q;
          fin_occ  = ent_rd.occ;
          if (!lookup_q && (ent_rd.occ != vhc_pkg::OCC_MAX)) begin
            ent_we        = 1'b1;
            ent_waddr     = ent_q;
            ent_wdata.occ = ent_rd.occ + 1'b1;
            fin_occ       = ent_rd.occ + 1'b1;
          end
        end else if (cnt_q == SlotW'(vhc_pkg::TABLE_SLOTS - 1)) begin
          // Whole table walked without a hit or a hole
          state_d  = S_IDLE;
          finish   = 1'b1;
          fin_stat = lookup_q ? vhc_pkg::STAT_NOT_FOUND : vhc_pkg::STAT_FULL;
          fin_slot = home_q;
        end else begin
          slot_d  = slot_q + 1'b1;
          cnt_d   = cnt_q + 1'b1;
          state_d = S_SLOT;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      used_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      used_q  <= used_d;
      if (finish) begin
        ov_q <= 1'b1;
      end else if (out_beat) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Probe context and result payload
  always_ff @(posedge clk_i) begin
    slot_q   <= slot_d;
    home_q   <= home_d;
    cnt_q    <= cnt_d;
    ent_q    <= ent_d;
    len_q    <= len_d;
    lookup_q <= lookup_d;
    if (finish) begin
      ostat_q <= fin_stat;
      oent_q  <= fin_ent;
      oocc_q  <= fin_occ;
      oslot_q <= fin_slot;
    end
  end

  assign in_i.ready        = in_ready;
  assign out_o.valid       = ov_q;
  assign out_o.status      = ostat_q;
  assign out_o.entry_index = oent_q;
  assign out_o.occurrences = oocc_q;
  assign out_o.slot_index  = oslot_q;

endmodule

// ===== hdl/vhc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vhc_checker
// Port-level checks on the vocabulary hash counter, bound to the top level.
// ----------------------------------------------------------------------------
`include "vocab_hash_counter_unit_macros.svh"

module vhc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [vhc_pkg::StatusW-1:0]      status,
  input logic [vhc_pkg::EntryW-1:0]       entry_index,
  input logic [vhc_pkg::OccW-1:0]         occurrences,
  input logic [vhc_pkg::SlotW-1:0]        slot_index
);

  // A stalled result beat holds
  `VHC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(occurrences), "result beat changed while stalled")

  // A stalled result blocks new key bytes
  `VHC_ASSERT_IMPLY(a_stall_blocks_in, out_valid && !out_ready, !in_ready, "input ready while result stalled")

  // A fresh entry starts at one
  `VHC_ASSERT_IMPLY(a_insert_one, out_valid && (status == vhc_pkg::STAT_INSERTED), occurrences == 1, "inserted entry count not one")

  // Misses carry no entry
  `VHC_ASSERT_IMPLY(a_miss_zero, out_valid && (status == vhc_pkg::STAT_NOT_FOUND || status == vhc_pkg::STAT_FULL || status == vhc_pkg::STAT_TOO_LONG), entry_index == 0 && occurrences == 0, "miss result carries an entry")

  // An overlong key never probed
  `VHC_ASSERT_IMPLY(a_long_slot, out_valid && (status == vhc_pkg::STAT_TOO_LONG), slot_index == 0, "overlong key reports a slot")

endmodule

bind vocab_hash_counter_unit vhc_checker u_vhc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready    (in_i.ready),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .status      (out_o.status),
  .entry_index (out_o.entry_index),
  .occurrences (out_o.occurrences),
  .slot_index  (out_o.slot_index)
);
